### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Assert that prop holds at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Assert that cond implies prop at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_IMPL(label, clk, rst_n, cond, prop)
`endif
`endif

### rtl/core/s128alu_pkg.sv
// Shared types and constants of the 128-bit ALU.
`default_nettype none
package s128alu_pkg;
    localparam int unsigned DataWidth = 128;
    localparam int unsigned HalfWidth = 64;
    localparam int unsigned ShiftMax  = 128;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
        OP_AND = 4'd4, OP_OR  = 4'd5, OP_XOR = 4'd6, OP_NOT = 4'd7,
        OP_SHL = 4'd8, OP_SAR = 4'd9, OP_ROL = 4'd10, OP_ROR = 4'd11
    } op_t;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_OVF = 2'd1, ST_DIVZ = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_DIV, S_SHIFT, S_FIX, S_DONE
    } state_t;
endpackage
`default_nettype wire

### rtl/core/signed_int128_alu.sv
// Top level of the signed 128-bit ALU.
// Usage: drive req_type, operands and shift_amount and pulse start while
// busy is low; that edge accepts the beat. busy stays high until the
// result beat, which appears on result_hi/result_lo/status for exactly one
// cycle with done high. The receiver cannot stall; the result must be taken.
// Steps from the accepting edge to the result beat:
//   add, sub, logic ops, div-by-zero/overflow cases: result beat in the next cycle
//   mul: 128 Booth steps through the shared adder
//   div: two magnitude setups, 128 restoring steps, sign fix
//   shifts/rotates: one bit per cycle, up to 128 bits, then the result beat
// A new request is taken in the cycle after done.
// All arithmetic goes through one 128-bit adder under the sequencer.
// Reset (rst_n low, asynchronous) returns to idle and drops busy and done.
`default_nettype none
module signed_int128_alu #(
    parameter int unsigned W = s128alu_pkg::DataWidth
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    output logic                    done,
    input  wire logic [3:0]         req_type,
    input  wire logic [W/2-1:0]     operand_a_hi,
    input  wire logic [W/2-1:0]     operand_a_lo,
    input  wire logic [W/2-1:0]     operand_b_hi,
    input  wire logic [W/2-1:0]     operand_b_lo,
    input  wire logic [$clog2(W):0] shift_amount,
    output logic [W/2-1:0]          result_hi,
    output logic [W/2-1:0]          result_lo,
    output logic [1:0]              status
);
    import s128alu_pkg::*;
    logic [W-1:0] res;
    status_t      st;

    s128alu_core #(.W(W)) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (start),
        .op    (op_t'(req_type)),
        .a     ({operand_a_hi, operand_a_lo}),
        .b     ({operand_b_hi, operand_b_lo}),
        .n     (shift_amount),
        .busy  (busy),
        .done  (done),
        .res   (res),
        .st    (st)
    );

    assign result_hi = res[W-1:W/2];
    assign result_lo = res[W/2-1:0];
    assign status    = st;
endmodule
`default_nettype wire

### rtl/core/s128alu_core.sv
// Sequencer and shared 128-bit adder that carry out all operations.
`default_nettype none
`include "assert_macros.svh"
module s128alu_core #(
    parameter int unsigned W = s128alu_pkg::DataWidth
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                go,
    input  wire s128alu_pkg::op_t    op,
    input  wire logic [W-1:0]        a,
    input  wire logic [W-1:0]        b,
    input  wire logic [$clog2(W):0]  n,
    output logic                     busy,
    output logic                     done,
    output logic [W-1:0]             res,
    output s128alu_pkg::status_t     st
);
    import s128alu_pkg::*;
    localparam int unsigned CW = $clog2(W);

    state_t state_reg, state_next;
    logic [CW:0]   cnt_reg, cnt_next;
    logic [W-1:0]  acc_reg, acc_next;     // mul high half / div remainder / shift data
    logic [W-1:0]  q_reg, q_next;         // mul low half (multiplier) / div quotient
    logic [W-1:0]  m_reg, m_next;         // multiplicand / divisor magnitude
    logic          qm1_reg, qm1_next;     // Booth previous bit
    logic          neg_reg, neg_next;     // result sign fix for div
    logic          sar_reg, sar_next;     // fill bit for shifts
    logic          rot_reg, rot_next;
    logic          left_reg, left_next;
    logic [W-1:0]  res_reg, res_next;
    status_t       st_reg, st_next;

    // Shared adder: x + (y ^ inv) + inv
    logic [W-1:0] add_x, add_y;
    logic         add_inv;
    logic [W:0]   add_sum;
    assign add_sum = {1'b0, add_x} + {1'b0, add_y ^ {W{add_inv}}} + {{W{1'b0}}, add_inv};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk) begin
        acc_reg  <= acc_next;
        q_reg    <= q_next;
        m_reg    <= m_next;
        qm1_reg  <= qm1_next;
        neg_reg  <= neg_next;
        sar_reg  <= sar_next;
        rot_reg  <= rot_next;
        left_reg <= left_next;
        res_reg  <= res_next;
        st_reg   <= st_next;
    end

    logic [W-1:0] rem_sh;
    logic [W-1:0] bool_res;
    logic         a_neg, b_neg, r_neg;
    logic [W-1:0] booth_hi;
    logic         booth_sgn;
    logic [W:0]   ext_bits;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        q_next     = q_reg;
        m_next     = m_reg;
        qm1_next   = qm1_reg;
        neg_next   = neg_reg;
        sar_next   = sar_reg;
        rot_next   = rot_reg;
        left_next  = left_reg;
        res_next   = res_reg;
        st_next    = st_reg;
        add_x      = a;
        add_y      = b;
        add_inv    = 1'b0;
        a_neg      = a[W-1];
        b_neg      = b[W-1];
        r_neg      = 1'b0;
        rem_sh     = '0;
        bool_res   = '0;
        booth_hi   = '0;
        booth_sgn  = 1'b0;
        ext_bits   = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (go) begin
                    st_next = ST_OK;
                    cnt_next = '0;
                    case (op)
                        OP_ADD, OP_SUB:
                        begin
                            add_inv = (op == OP_SUB);
                            r_neg = add_sum[W-1];
                            res_next = add_sum[W-1:0];
                            if ((a_neg == (b_neg ^ add_inv)) && (r_neg != a_neg))
                                st_next = ST_OVF;
                            state_next = S_DONE;
                        end
                        OP_MUL:
                        begin
                            acc_next = '0;
                            q_next = b;
                            m_next = a;
                            qm1_next = 1'b0;
                            state_next = S_MUL;
                        end
                        OP_DIV:
                        begin
                            res_next = '0;
                            if (b == '0) begin
                                st_next = ST_DIVZ;
                                state_next = S_DONE;
                            end else if (a == {1'b1, {(W-1){1'b0}}} && b == {W{1'b1}}) begin
                                st_next = ST_OVF;
                                state_next = S_DONE;
                            end else begin
                                // first setup step: magnitude of a
                                add_x = '0;
                                add_y = a;
                                add_inv = a_neg;
                                q_next = a_neg ? add_sum[W-1:0] : a;
                                m_next = b;
                                acc_next = '0;
                                neg_next = a_neg ^ b_neg;
                                state_next = S_FIX;
                            end
                        end
                        OP_AND, OP_OR, OP_XOR, OP_NOT:
                        begin
                            case (op)
                                OP_AND: bool_res = a & b;
                                OP_OR:  bool_res = a | b;
                                OP_XOR: bool_res = a ^ b;
                                default: bool_res = ~a;
                            endcase
                            res_next = bool_res;
                            state_next = S_DONE;
                        end
                        OP_SHL, OP_SAR, OP_ROL, OP_ROR:
                        begin
                            acc_next = a;
                            left_next = (op == OP_SHL) || (op == OP_ROL);
                            rot_next = (op == OP_ROL) || (op == OP_ROR);
                            sar_next = (op == OP_SAR) & a_neg;
                            cnt_next = (n > (CW+1)'(W)) ? (CW+1)'(W) : n;
                            // a rotate count of W or more gives no rotation; W itself is a full turn
                            if (rot_next) cnt_next = n[CW] ? '0 : {1'b0, n[CW-1:0]};
                            state_next = S_SHIFT;
                        end
                        default:
                        begin
                            res_next = '0;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_FIX:
            begin
                // second setup step: magnitude of divisor
                add_x = '0;
                add_y = m_reg;
                add_inv = m_reg[W-1];
                m_next = m_reg[W-1] ? add_sum[W-1:0] : m_reg;
                cnt_next = (CW+1)'(W);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (cnt_reg == '0) begin
                    add_x = '0;
                    add_y = q_reg;
                    add_inv = neg_reg;
                    res_next = neg_reg ? add_sum[W-1:0] : q_reg;
                    state_next = S_DONE;
                end else begin
                    rem_sh = {acc_reg[W-2:0], q_reg[W-1]};
                    add_x = rem_sh;
                    add_y = m_reg;
                    add_inv = 1'b1;
                    // top bit of acc set means shifted value exceeds 128 bits
                    if (add_sum[W] || acc_reg[W-1]) begin
                        acc_next = add_sum[W-1:0];
                        q_next = {q_reg[W-2:0], 1'b1};
                    end else begin
                        acc_next = rem_sh;
                        q_next = {q_reg[W-2:0], 1'b0};
                    end
                    cnt_next = cnt_reg - (CW+1)'(1);
                end
            end
            S_MUL:
            begin
                // radix-2 Booth step on {acc, q, qm1}; sign taken from the W+1 bit sum
                add_x = acc_reg;
                add_y = m_reg;
                add_inv = q_reg[0];
                booth_hi = acc_reg;
                booth_sgn = acc_reg[W-1];
                if (q_reg[0] != qm1_reg) begin
                    booth_hi = add_sum[W-1:0];
                    booth_sgn = acc_reg[W-1] ^ m_reg[W-1] ^ add_inv ^ add_sum[W];
                end
                acc_next = {booth_sgn, booth_hi[W-1:1]};
                q_next = {booth_hi[0], q_reg[W-1:1]};
                qm1_next = q_reg[0];
                cnt_next = cnt_reg + (CW+1)'(1);
                if (cnt_reg == (CW+1)'(W-1)) begin
                    res_next = q_next;
                    ext_bits = {acc_next, q_next[W-1]};
                    if (!(ext_bits == '0 || ext_bits == {(W+1){1'b1}}))
                        st_next = ST_OVF;
                    state_next = S_DONE;
                end
            end
            S_SHIFT:
            begin
                if (cnt_reg == '0) begin
                    res_next = acc_reg;
                    state_next = S_DONE;
                end else begin
                    if (left_reg)
                        acc_next = {acc_reg[W-2:0], rot_reg ? acc_reg[W-1] : 1'b0};
                    else
                        acc_next = {rot_reg ? acc_reg[0] : sar_reg, acc_reg[W-1:1]};
                    cnt_next = cnt_reg - (CW+1)'(1);
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);
    assign res  = res_reg;
    assign st   = st_reg;

    `ASSERT_IMPL(a_go_leaves_idle, clk, rst_n, go && !busy, state_next != S_IDLE)
    `ASSERT_IMPL(a_done_one_beat, clk, rst_n, done, ##1 !done)
    `ASSERT_IMPL(a_divz_zero, clk, rst_n, done && st_reg == ST_DIVZ, res_reg == '0)
    `ASSERT_CLK(a_cnt_range, clk, rst_n, cnt_reg <= (CW+1)'(W))
endmodule
`default_nettype wire
